[rtl/ffpa_pkg.sv]
// ----------------------------------------------------------------------------
// ffpa_pkg
// Shared types and codes of the first-fit pool allocator.
// ----------------------------------------------------------------------------
package ffpa_pkg;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic STATUS_OK   = 1'b0;
  localparam logic STATUS_FAIL = 1'b1;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK,
    S_FREE,
    S_TAIL,
    S_PREV,
    S_CUR,
    S_RESP
  } state_e;

endpackage

[rtl/ffpa_mem.sv]
// ----------------------------------------------------------------------------
// ffpa_mem
// Header memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module ffpa_mem #(
  parameter int Depth = 4096,
  parameter int Width = 26
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[rtl/first_fit_pool_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_pool_allocator
// First-fit allocator over a byte pool with in-band headers and a free list.
// ----------------------------------------------------------------------------
// All block headers (size, next link, taken mark) live in one synchronous
// memory of POOL_BYTES words. After reset a clearing pass initializes that
// memory, and no item is accepted meanwhile. One item is handled at a time.
// A free pushes a taken header onto the free list; an address below the
// header size is refused at once. An allocation reads one header per cycle
// while walking the free list; on a fit it writes the tail header when the
// block is split, relinks the previous block and marks the block taken.
// Zero requests and an empty list are refused without a walk.
module first_fit_pool_allocator #(
  parameter int POOL_BYTES   = 4096,
  parameter int HEADER_BYTES = 16,
  parameter int SPLIT_SLACK  = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        req_type_i,
  input  logic [11:0] req_size_i,
  input  logic [11:0] payload_addr_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        status_o,
  output logic [11:0] addr_out_o
);
  import ffpa_pkg::*;

  localparam int AW = $clog2(POOL_BYTES);
  localparam int LW = AW + 1;
  localparam int CW = ((AW > 12) ? AW : 12) + 3;
  localparam int WW = 1 + LW + AW;
  localparam logic [LW-1:0] NONE_C = LW'(POOL_BYTES);
  localparam logic [CW-1:0] POOL_C = CW'(POOL_BYTES);
  localparam logic [CW-1:0] HDR_C = CW'(HEADER_BYTES);
  localparam logic [CW-1:0] SLACK_C = CW'(SPLIT_SLACK);
  localparam logic [AW-1:0] INIT_SIZE_C = AW'(POOL_BYTES - HEADER_BYTES);

  state_e state_q, state_d;

  logic          split_q;
  logic [LW-1:0] head_q, head_d;
  logic [AW-1:0] cur_q, cur_d;
  logic [LW-1:0] prev_q, prev_d;
  logic [WW-1:0] prev_word_q, prev_word_d;
  logic [AW-1:0] cur_size_q, cur_size_d;
  logic [LW-1:0] cur_link_q, cur_link_d;
  logic [11:0]   want_q, want_d;
  logic [LW-1:0] steps_q, steps_d;
  logic [AW-1:0] tail_q, tail_d;
  logic [AW-1:0] tail_size_q, tail_size_d;
  logic [LW-1:0] newlink_q, newlink_d;
  logic          do_split_q, do_split_d;
  logic [AW-1:0] clr_q, clr_d;
  logic          res_status_q, res_status_d;
  logic [11:0]   res_addr_q, res_addr_d;
  logic          out_vld_q, out_vld_d;
  logic          out_status_q, out_status_d;
  logic [11:0]   out_addr_q, out_addr_d;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [WW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [WW-1:0] mem_rdata;

  ffpa_mem #(
    .Depth(POOL_BYTES),
    .Width(WW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  logic          rd_taken;
  logic [LW-1:0] rd_link;
  logic [AW-1:0] rd_size;
  assign {rd_taken, rd_link, rd_size} = mem_rdata;

  logic          accept;
  logic [CW-1:0] want_w, size_w, payload_w, hdr_w, tail_w;
  logic          fit, split_ok, walk_end, alloc_bad, free_bad, out_free;
  logic [LW-1:0] steps_inc;

  assign accept    = in_valid_i && !in_stall_o;
  assign want_w    = CW'(want_q);
  assign size_w    = CW'(rd_size);
  assign payload_w = CW'(payload_addr_i);
  assign hdr_w     = payload_w - HDR_C;
  assign tail_w    = CW'(cur_q) + HDR_C + want_w;
  assign fit       = size_w >= want_w;
  assign split_ok  = split_q && (size_w > want_w + (HDR_C << 1) + SLACK_C) &&
                     (tail_w < POOL_C);
  assign steps_inc = steps_q + LW'(1);
  assign walk_end  = (rd_link >= NONE_C) || (steps_inc == NONE_C);
  assign alloc_bad = (req_size_i == '0) || (head_q >= NONE_C);
  assign free_bad  = (payload_w < HDR_C) || (hdr_w >= POOL_C);
  assign out_free  = !out_vld_q || !out_stall_i;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_vld_q;
  assign status_o    = out_status_q;
  assign addr_out_o  = out_addr_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_CLEAR: begin
        if (clr_q == AW'(POOL_BYTES - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          if (req_type_i == REQ_ALLOC) begin
            state_d = alloc_bad ? S_RESP : S_WALK;
          end else begin
            state_d = free_bad ? S_RESP : S_FREE;
          end
        end
      end
      S_WALK: begin
        if (fit) begin
          state_d = split_ok ? S_TAIL : S_PREV;
        end else if (walk_end) begin
          state_d = S_RESP;
        end
      end
      S_FREE: state_d = S_RESP;
      S_TAIL: state_d = S_PREV;
      S_PREV: state_d = S_CUR;
      S_CUR:  state_d = S_RESP;
      S_RESP: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    head_d       = head_q;
    cur_d        = cur_q;
    prev_d       = prev_q;
    prev_word_d  = prev_word_q;
    cur_size_d   = cur_size_q;
    cur_link_d   = cur_link_q;
    want_d       = want_q;
    steps_d      = steps_q;
    tail_d       = tail_q;
    tail_size_d  = tail_size_q;
    newlink_d    = newlink_q;
    do_split_d   = do_split_q;
    clr_d        = clr_q;
    res_status_d = res_status_q;
    res_addr_d   = res_addr_q;
    out_vld_d    = out_vld_q && out_stall_i;
    out_status_d = out_status_q;
    out_addr_d   = out_addr_q;
    mem_we       = 1'b0;
    mem_waddr    = cur_q;
    mem_wdata    = '0;
    mem_raddr    = cur_q;
    case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = (clr_q == '0) ? {1'b0, NONE_C, INIT_SIZE_C} : '0;
        clr_d     = clr_q + AW'(1);
      end
      S_IDLE: begin
        want_d       = req_size_i;
        res_status_d = STATUS_FAIL;
        res_addr_d   = '0;
        steps_d      = '0;
        prev_d       = NONE_C;
        if (req_type_i == REQ_ALLOC) begin
          cur_d     = head_q[AW-1:0];
          mem_raddr = head_q[AW-1:0];
        end else begin
          cur_d     = hdr_w[AW-1:0];
          mem_raddr = hdr_w[AW-1:0];
        end
      end
      S_WALK: begin
        cur_size_d  = rd_size;
        cur_link_d  = rd_link;
        do_split_d  = split_ok;
        tail_d      = tail_w[AW-1:0];
        tail_size_d = AW'(size_w - HDR_C - want_w);
        newlink_d   = split_ok ? LW'(tail_w) : rd_link;
        if (!fit) begin
          prev_d      = LW'(cur_q);
          prev_word_d = mem_rdata;
          cur_d       = rd_link[AW-1:0];
          steps_d     = steps_inc;
          mem_raddr   = rd_link[AW-1:0];
        end
      end
      S_FREE: begin
        if (rd_taken) begin
          mem_we       = 1'b1;
          mem_wdata    = {1'b0, head_q, rd_size};
          head_d       = LW'(cur_q);
          res_status_d = STATUS_OK;
        end
      end
      S_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = tail_q;
        mem_wdata = {1'b0, cur_link_q, tail_size_q};
      end
      S_PREV: begin
        if (prev_q < NONE_C) begin
          mem_we    = 1'b1;
          mem_waddr = prev_q[AW-1:0];
          mem_wdata = {prev_word_q[WW-1], newlink_q, prev_word_q[AW-1:0]};
        end else begin
          head_d = newlink_q;
        end
      end
      S_CUR: begin
        mem_we       = 1'b1;
        mem_wdata    = {1'b1, NONE_C, do_split_q ? AW'(want_q) : cur_size_q};
        res_status_d = STATUS_OK;
        res_addr_d   = 12'(CW'(cur_q) + HDR_C);
      end
      S_RESP: begin
        if (out_free) begin
          out_vld_d    = 1'b1;
          out_status_d = res_status_q;
          out_addr_d   = res_addr_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      split_q   <= 1'b0;
      head_q    <= '0;
      clr_q     <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      head_q    <= head_d;
      clr_q     <= clr_d;
      out_vld_q <= out_vld_d;
      if (cfg_valid_i && cfg_ready_o) begin
        split_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q        <= cur_d;
    prev_q       <= prev_d;
    prev_word_q  <= prev_word_d;
    cur_size_q   <= cur_size_d;
    cur_link_q   <= cur_link_d;
    want_q       <= want_d;
    steps_q      <= steps_d;
    tail_q       <= tail_d;
    tail_size_q  <= tail_size_d;
    newlink_q    <= newlink_d;
    do_split_q   <= do_split_d;
    res_status_q <= res_status_d;
    res_addr_q   <= res_addr_d;
    out_status_q <= out_status_d;
    out_addr_q   <= out_addr_d;
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_WALK || state_q == S_RESP) |-> !mem_we)
    else $error("Header memory written outside an update step.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && out_status_q == STATUS_FAIL) |-> (out_addr_q == '0))
    else $error("Failed item carries a nonzero address.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RESP && out_vld_q && out_stall_i) |=> (state_q == S_RESP))
    else $error("Result dropped while the output was stalled.");

endmodule

[tb/sv/first_fit_pool_allocator_tb.sv]
// ----------------------------------------------------------------------------
// first_fit_pool_allocator_tb
// Self-checking testbench of the first-fit pool allocator. A directed table
// covers the extremes and the failure codes, then phases of random allocate
// and free items run with splitting on and off. Every result is compared with
// a behavioral copy of the allocator's free list kept inside the testbench.
// ----------------------------------------------------------------------------
module first_fit_pool_allocator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffpa_pkg::*;

  localparam int POOL   = 4096;
  localparam int HDR    = 16;
  localparam int SLACK  = 32;
  localparam int NRAND  = 1500;

  typedef struct packed {
    logic        status;
    logic [11:0] addr;
  } alloc_result_t;

  typedef struct {
    logic        split;
    logic        kind;
    logic [11:0] size;
    logic [11:0] addr;
    bit          known;
    logic        status;
    logic [11:0] addr_exp;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_data_i = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic        req_type_i = REQ_ALLOC;
  logic [11:0] req_size_i = '0;
  logic [11:0] payload_addr_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic        status_o;
  logic [11:0] addr_out_o;

  first_fit_pool_allocator dut (
    .clk_i, .rst_ni, .cfg_valid_i, .cfg_ready_o, .cfg_data_i,
    .in_valid_i, .in_stall_o, .req_type_i, .req_size_i, .payload_addr_i,
    .out_valid_o, .out_stall_i, .status_o, .addr_out_o
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  initial begin
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

  // Copy of the allocator's state.
  logic        split_on;
  logic [12:0] free_head;
  logic [11:0] hdr_size [POOL];
  logic [12:0] hdr_link [POOL];
  bit          hdr_taken [POOL];
  logic [11:0] live_addrs [$];
  logic [11:0] last_freed;

  alloc_result_t pending_results [$];
  int errors, n_alloc_ok, n_alloc_fail, n_free_ok, n_free_ign, n_checked;
  bit gaps_on;
  bit hold_done;

  task automatic predict_request(input logic kind, input logic [11:0] size,
                                 input logic [11:0] addr, output alloc_result_t res);
    int cur, prev, steps, tail, hdr;
    cur = free_head;
    prev = POOL;
    steps = 0;
    res = '{status: STATUS_FAIL, addr: 12'd0};
    if (kind == REQ_ALLOC) begin
      if (size != 0) begin
        while (cur < POOL && steps < POOL) begin
          if (hdr_size[cur] >= size) begin
            if (split_on && hdr_size[cur] > size + 2 * HDR + SLACK) begin
              tail = cur + HDR + size;
              if (tail < POOL) begin
                hdr_size[tail] = hdr_size[cur] - HDR - size;
                hdr_link[tail] = hdr_link[cur];
                hdr_taken[tail] = 1'b0;
                hdr_link[cur] = 13'(tail);
                hdr_size[cur] = size;
              end
            end
            if (prev < POOL) hdr_link[prev] = hdr_link[cur];
            else free_head = hdr_link[cur];
            hdr_link[cur] = 13'(POOL);
            hdr_taken[cur] = 1'b1;
            res = '{status: STATUS_OK, addr: 12'(cur + HDR)};
            live_addrs.push_back(12'(cur + HDR));
            break;
          end
          prev = cur;
          cur = hdr_link[cur];
          steps++;
        end
      end
      if (res.status == STATUS_OK) n_alloc_ok++;
      else n_alloc_fail++;
    end else begin
      if (addr >= HDR) begin
        hdr = addr - HDR;
        if (hdr < POOL && hdr_taken[hdr]) begin
          hdr_taken[hdr] = 1'b0;
          hdr_link[hdr] = free_head;
          free_head = 13'(hdr);
          res = '{status: STATUS_OK, addr: 12'd0};
          last_freed = addr;
          foreach (live_addrs[i]) if (live_addrs[i] == addr) begin
            live_addrs.delete(i);
            break;
          end
        end
      end
      if (res.status == STATUS_OK) n_free_ok++;
      else n_free_ign++;
    end
  endtask

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!gaps_on || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input logic kind, input logic [11:0] size,
                              input logic [11:0] addr, output alloc_result_t res);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= kind;
    req_size_i <= size;
    payload_addr_i <= addr;
    do @(posedge clk_i); while (in_stall_o);
    predict_request(kind, size, addr, res);
    pending_results.push_back(res);
  endtask

  task automatic drain_and_configure(input logic value);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    split_on = value;
    cfg_valid_i <= 1'b0;
  endtask

  // Receiver: checks results and stalls at random, once for a long stretch.
  initial begin
    int stall_left;
    alloc_result_t want;
    stall_left = 0;
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result status=%0b addr=%0d", $time, status_o,
                   addr_out_o);
          errors++;
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (status_o !== want.status) begin
            $display("%0t: status expected %0b actual %0b", $time, want.status, status_o);
            errors++;
          end
          if (addr_out_o !== want.addr) begin
            $display("%0t: addr_out expected %0d actual %0d", $time, want.addr,
                     addr_out_o);
            errors++;
          end
        end
      end
      if (!hold_done && n_checked == 300) begin
        hold_done = 1'b1;
        stall_left = 400;
      end else if (stall_left == 0 && gaps_on && $urandom_range(0, 99) < 30) begin
        stall_left = ($urandom_range(0, 9) < 9) ? $urandom_range(1, 3)
                                                : $urandom_range(10, 40);
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  stim_row_t table_rows [] = '{
    '{1'b0, REQ_ALLOC, 12'd0,    12'd0,    1'b1, STATUS_FAIL, 12'd0},
    '{1'b0, REQ_ALLOC, 12'd4080, 12'd0,    1'b1, STATUS_OK,   12'd16},
    '{1'b0, REQ_ALLOC, 12'd1,    12'd0,    1'b1, STATUS_FAIL, 12'd0},
    '{1'b0, REQ_FREE,  12'd0,    12'd0,    1'b1, STATUS_FAIL, 12'd0},
    '{1'b0, REQ_FREE,  12'd0,    12'd15,   1'b1, STATUS_FAIL, 12'd0},
    '{1'b0, REQ_FREE,  12'd4095, 12'd4095, 1'b1, STATUS_FAIL, 12'd0},
    '{1'b0, REQ_FREE,  12'd0,    12'd16,   1'b1, STATUS_OK,   12'd0},
    '{1'b0, REQ_FREE,  12'd0,    12'd16,   1'b1, STATUS_FAIL, 12'd0},
    '{1'b0, REQ_ALLOC, 12'd4095, 12'd0,    1'b1, STATUS_FAIL, 12'd0},
    '{1'b0, REQ_ALLOC, 12'd4080, 12'd0,    1'b1, STATUS_OK,   12'd16},
    '{1'b0, REQ_FREE,  12'd0,    12'd16,   1'b1, STATUS_OK,   12'd0},
    '{1'b1, REQ_ALLOC, 12'd1,    12'd0,    1'b1, STATUS_OK,   12'd16},
    '{1'b1, REQ_ALLOC, 12'd4095, 12'd0,    1'b1, STATUS_FAIL, 12'd0},
    '{1'b1, REQ_ALLOC, 12'd100,  12'd0,    1'b0, 1'b0,        12'd0},
    '{1'b1, REQ_ALLOC, 12'd48,   12'd0,    1'b0, 1'b0,        12'd0},
    '{1'b1, REQ_FREE,  12'd0,    12'd16,   1'b0, 1'b0,        12'd0},
    '{1'b1, REQ_ALLOC, 12'd2,    12'd0,    1'b0, 1'b0,        12'd0},
    '{1'b1, REQ_ALLOC, 12'd1,    12'd0,    1'b0, 1'b0,        12'd0},
    '{1'b1, REQ_FREE,  12'd0,    12'd33,   1'b0, 1'b0,        12'd0},
    '{1'b1, REQ_ALLOC, 12'd3900, 12'd0,    1'b0, 1'b0,        12'd0},
    '{1'b1, REQ_ALLOC, 12'd4000, 12'd0,    1'b0, 1'b0,        12'd0}
  };

  initial begin
    alloc_result_t res;
    logic kind;
    logic [11:0] size, addr;
    int r;
    split_on = 1'b0;
    free_head = 13'd0;
    foreach (hdr_size[i]) begin
      hdr_size[i] = '0;
      hdr_link[i] = '0;
      hdr_taken[i] = 1'b0;
    end
    hdr_size[0] = 12'(POOL - HDR);
    hdr_link[0] = 13'(POOL);
    last_freed = 12'd16;
    gaps_on = 1'b1;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (table_rows[i]) begin
      if (table_rows[i].split != split_on) drain_and_configure(table_rows[i].split);
      send_request(table_rows[i].kind, table_rows[i].size, table_rows[i].addr, res);
      if (table_rows[i].known &&
          (res.status !== table_rows[i].status || res.addr !== table_rows[i].addr_exp)) begin
        $display("%0t: row %0d expected %0b/%0d actual %0b/%0d", $time, i,
                 table_rows[i].status, table_rows[i].addr_exp, res.status, res.addr);
        errors++;
      end
    end

    for (int n = 0; n < NRAND; n++) begin
      if (n % 500 == 0) drain_and_configure(n % 1000 == 0 ? 1'b0 : 1'b1);
      if (n % 100 == 0) gaps_on = ($urandom_range(0, 3) != 0);
      r = $urandom_range(0, 99);
      size = 12'd0;
      addr = 12'd0;
      if (r < 45) begin
        kind = REQ_ALLOC;
        size = ($urandom_range(0, 9) < 8) ? 12'($urandom_range(1, 96))
                                          : 12'($urandom_range(0, 4095));
        addr = 12'($urandom_range(0, 4095));
      end else if (r < 88 && live_addrs.size() != 0) begin
        kind = REQ_FREE;
        addr = live_addrs[$urandom_range(0, live_addrs.size() - 1)];
        size = 12'($urandom_range(0, 4095));
      end else begin
        kind = REQ_FREE;
        addr = ($urandom_range(0, 1) == 0) ? last_freed : 12'($urandom_range(0, 4095));
        size = 12'($urandom_range(0, 4095));
      end
      send_request(kind, size, addr, res);
    end

    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("Checked %0d results: %0d allocations granted, %0d refused,", n_checked,
             n_alloc_ok, n_alloc_fail);
    $display("%0d frees accepted, %0d ignored, with splitting on and off.", n_free_ok,
             n_free_ign);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
